// ----- rtl/integer_stack_machine_macros.svh -----
// Assertion macros used by the checker file.
`ifndef INTEGER_STACK_MACHINE_MACROS_SVH
`define INTEGER_STACK_MACHINE_MACROS_SVH

// A stalled channel keeps valid high and its payload steady.
`define ISM_ASSERT_HOLD(name, vld, stl, data, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) \
        ((vld) && (stl)) |=> ((vld) && $stable(data))) \
        else $error(msg);

// Plain implication, same cycle.
`define ISM_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> (cons)) \
        else $error(msg);

// Implication into the next cycle.
`define ISM_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/ism_pkg.sv -----
`default_nettype none

package ism_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int PTR_W       = $clog2(STACK_DEPTH + 1);
    localparam int WORD_W      = 32;
    localparam int MODE_W      = 4;
    localparam int POS_W       = 6;
    localparam int DEPTH_W     = 7;
    localparam int STATUS_W    = 2;

    localparam logic [MODE_W-1:0] MODE_CONST = 4'd0;
    localparam logic [MODE_W-1:0] MODE_ADD   = 4'd1;
    localparam logic [MODE_W-1:0] MODE_SUB   = 4'd2;
    localparam logic [MODE_W-1:0] MODE_MUL   = 4'd3;
    localparam logic [MODE_W-1:0] MODE_DIV   = 4'd4;
    localparam logic [MODE_W-1:0] MODE_MAX   = 4'd5;
    localparam logic [MODE_W-1:0] MODE_MIN   = 4'd6;
    localparam logic [MODE_W-1:0] MODE_NEG   = 4'd7;
    localparam logic [MODE_W-1:0] MODE_DUP   = 4'd8;
    localparam logic [MODE_W-1:0] MODE_SWAP  = 4'd9;
    localparam logic [MODE_W-1:0] MODE_DUMP  = 4'd10;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DIVZ  = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic signed [WORD_W-1:0] value;
    } instr_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] value_res;
        logic [POS_W-1:0]         position;
        logic [DEPTH_W-1:0]       depth;
        logic [STATUS_W-1:0]      status;
        logic                     last;
    } result_t;

    typedef enum logic [1:0] {
        WA_PUSH,
        WA_TOP,
        WA_SEC
    } wr_addr_t;

    typedef enum logic [2:0] {
        WS_VALUE,
        WS_TOP,
        WS_SEC,
        WS_ALU,
        WS_PROD,
        WS_QUO
    } wr_src_t;

    typedef enum logic [2:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MAX,
        ALU_MIN,
        ALU_NEG
    } alu_op_t;

    typedef enum logic [1:0] {
        SP_HOLD,
        SP_INC,
        SP_DEC
    } sp_op_t;

    typedef enum logic {
        RES_STEP,
        RES_DUMP
    } res_src_t;

    typedef struct packed {
        logic                rd_en;
        logic                rd_dump;
        logic                idx_clr;
        logic                idx_inc;
        logic                value_ld;
        logic                wr_en;
        wr_addr_t            wr_addr;
        wr_src_t             wr_src;
        alu_op_t             alu_op;
        sp_op_t              sp_op;
        logic                prod_ld;
        logic                div_start;
        logic                emit;
        res_src_t            res_src;
        logic [STATUS_W-1:0] status;
    } cmd_t;

    typedef struct packed {
        logic sp_empty;
        logic sp_lt2;
        logic sp_full;
        logic sec_zero;
        logic div_busy;
        logic out_free;
        logic dump_last;
    } stat_t;

endpackage

`default_nettype wire

// ----- rtl/ism_divider.sv -----
`default_nettype none

module ism_divider (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [ism_pkg::WORD_W-1:0]   dividend,
    input  logic [ism_pkg::WORD_W-1:0]   divisor,
    output logic                         busy,
    output logic [ism_pkg::WORD_W-1:0]   quotient
);
    import ism_pkg::*;

    localparam int CNT_W = $clog2(WORD_W);

    logic              busy_reg, busy_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] quo_reg, quo_next;
    logic [WORD_W-1:0] dsr_reg, dsr_next;
    logic [WORD_W:0]   rem_sh;
    logic [WORD_W+1:0] diff;

    // One restoring step per cycle: shift in the next dividend bit, try the subtract.
    assign rem_sh = {rem_reg, quo_reg[WORD_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[WORD_W+1])
            begin
                rem_next = diff[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(WORD_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ----- rtl/ism_datapath.sv -----
`default_nettype none

module ism_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ism_pkg::cmd_t                  cmd,
    input  logic signed [ism_pkg::WORD_W-1:0] instr_value,
    output ism_pkg::stat_t                 stat,
    output logic                           result_valid,
    input  logic                           result_stall,
    output ism_pkg::result_t               result
);
    import ism_pkg::*;

    logic signed [WORD_W-1:0] mem [STACK_DEPTH];

    logic signed [WORD_W-1:0] rd_a_reg, rd_b_reg;
    logic signed [WORD_W-1:0] val_reg;
    logic signed [WORD_W-1:0] prod_reg;
    logic                     q_neg_reg;
    logic [PTR_W-1:0]         sp_reg, sp_next;
    logic [ADDR_W-1:0]        idx_reg, idx_next;
    logic                     result_valid_reg, result_valid_next;
    result_t                  result_reg, result_next;

    logic [PTR_W-1:0]         sp_m1, sp_m2, sp_next_m1;
    logic [ADDR_W-1:0]        addr_top, addr_sec, addr_push, rd_a_addr, wr_addr;
    logic signed [WORD_W-1:0] alu_res, wdata, quo_signed, top_val;
    logic [WORD_W-1:0]        mag_t, mag_s, quo;
    logic                     div_busy;

    assign sp_m1     = sp_reg - PTR_W'(1);
    assign sp_m2     = sp_reg - PTR_W'(2);
    assign addr_top  = sp_m1[ADDR_W-1:0];
    assign addr_sec  = sp_m2[ADDR_W-1:0];
    assign addr_push = sp_reg[ADDR_W-1:0];
    assign rd_a_addr = cmd.rd_dump ? idx_reg : addr_top;

    always_comb
    begin
        unique case (cmd.wr_addr)
            WA_PUSH: wr_addr = addr_push;
            WA_TOP:  wr_addr = addr_top;
            WA_SEC:  wr_addr = addr_sec;
            default: wr_addr = addr_top;
        endcase
    end

    // Stack store: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wdata;
        end
        if (cmd.rd_en)
        begin
            rd_a_reg <= mem[rd_a_addr];
            rd_b_reg <= mem[addr_sec];
        end
    end

    always_comb
    begin
        case (cmd.alu_op)
            ALU_ADD: alu_res = rd_a_reg + rd_b_reg;
            ALU_SUB: alu_res = rd_a_reg - rd_b_reg;
            ALU_MAX: alu_res = (rd_b_reg > rd_a_reg) ? rd_b_reg : rd_a_reg;
            ALU_MIN: alu_res = (rd_b_reg > rd_a_reg) ? rd_a_reg : rd_b_reg;
            ALU_NEG: alu_res = -rd_a_reg;
            default: alu_res = rd_a_reg;
        endcase
    end

    // Magnitudes into the divider, sign fixed up on the way out.
    assign mag_t      = rd_a_reg[WORD_W-1] ? (WORD_W'(0) - rd_a_reg) : rd_a_reg;
    assign mag_s      = rd_b_reg[WORD_W-1] ? (WORD_W'(0) - rd_b_reg) : rd_b_reg;
    assign quo_signed = q_neg_reg ? -$signed(quo) : $signed(quo);

    ism_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (mag_t),
        .divisor  (mag_s),
        .busy     (div_busy),
        .quotient (quo)
    );

    always_comb
    begin
        case (cmd.wr_src)
            WS_VALUE: wdata = val_reg;
            WS_TOP:   wdata = rd_a_reg;
            WS_SEC:   wdata = rd_b_reg;
            WS_ALU:   wdata = alu_res;
            WS_PROD:  wdata = prod_reg;
            WS_QUO:   wdata = quo_signed;
            default:  wdata = rd_a_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.sp_op)
            SP_INC:  sp_next = sp_reg + PTR_W'(1);
            SP_DEC:  sp_next = sp_reg - PTR_W'(1);
            default: sp_next = sp_reg;
        endcase
    end

    assign sp_next_m1 = sp_next - PTR_W'(1);
    assign top_val    = (sp_reg == '0) ? '0 : rd_a_reg;
    assign idx_next   = cmd.idx_clr ? '0 : (cmd.idx_inc ? idx_reg + ADDR_W'(1) : idx_reg);

    always_comb
    begin
        if (cmd.res_src == RES_DUMP)
        begin
            result_next.value_res = rd_a_reg;
            result_next.position  = POS_W'(idx_reg);
            result_next.depth     = DEPTH_W'(sp_reg);
            result_next.status    = ST_OK;
            result_next.last      = stat.dump_last;
        end
        else
        begin
            result_next.value_res = cmd.wr_en ? wdata : top_val;
            result_next.position  = (sp_next == '0) ? '0 : POS_W'(sp_next_m1);
            result_next.depth     = DEPTH_W'(sp_next);
            result_next.status    = cmd.status;
            result_next.last      = 1'b1;
        end
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (cmd.emit)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg           <= '0;
            idx_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            sp_reg           <= sp_next;
            idx_reg          <= idx_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.value_ld)
        begin
            val_reg <= instr_value;
        end
        if (cmd.prod_ld)
        begin
            prod_reg <= rd_a_reg * rd_b_reg;
        end
        if (cmd.div_start)
        begin
            q_neg_reg <= rd_a_reg[WORD_W-1] ^ rd_b_reg[WORD_W-1];
        end
        if (cmd.emit)
        begin
            result_reg <= result_next;
        end
    end

    assign stat.sp_empty  = (sp_reg == '0);
    assign stat.sp_lt2    = (sp_reg < PTR_W'(2));
    assign stat.sp_full   = (sp_reg >= PTR_W'(STACK_DEPTH));
    assign stat.sec_zero  = (rd_b_reg == '0);
    assign stat.div_busy  = div_busy;
    assign stat.out_free  = !result_valid_reg || !result_stall;
    assign stat.dump_last = (PTR_W'(idx_reg) == sp_m1);

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

// ----- rtl/ism_ctrl.sv -----
`default_nettype none

module ism_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         instr_valid,
    output logic                         instr_stall,
    input  logic [ism_pkg::MODE_W-1:0]   mode,
    input  ism_pkg::stat_t               stat,
    output ism_pkg::cmd_t                cmd
);
    import ism_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_EXEC    = 7'b0000010,
        S_MUL_WR  = 7'b0000100,
        S_DIV_WR  = 7'b0001000,
        S_SWAP_WR = 7'b0010000,
        S_DUMP_RD = 7'b0100000,
        S_DUMP_EM = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic [MODE_W-1:0] mode_reg, mode_next;

    always_comb
    begin
        cmd         = '0;
        cmd.wr_addr = WA_TOP;
        cmd.wr_src  = WS_TOP;
        cmd.alu_op  = ALU_ADD;
        cmd.sp_op   = SP_HOLD;
        cmd.res_src = RES_STEP;
        cmd.status  = ST_OK;
        state_next  = state_reg;
        mode_next   = mode_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                cmd.rd_en   = 1'b1;
                cmd.idx_clr = 1'b1;
                if (instr_valid)
                begin
                    cmd.value_ld = 1'b1;
                    mode_next    = mode;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (mode_reg) inside
                    MODE_CONST:
                    begin
                        if (stat.out_free)
                        begin
                            cmd.emit   = 1'b1;
                            state_next = S_IDLE;
                            if (stat.sp_full)
                            begin
                                cmd.status = ST_OVER;
                            end
                            else
                            begin
                                cmd.wr_en   = 1'b1;
                                cmd.wr_addr = WA_PUSH;
                                cmd.wr_src  = WS_VALUE;
                                cmd.sp_op   = SP_INC;
                            end
                        end
                    end
                    MODE_DUP:
                    begin
                        if (stat.out_free)
                        begin
                            cmd.emit   = 1'b1;
                            state_next = S_IDLE;
                            if (stat.sp_empty)
                            begin
                                cmd.status = ST_UNDER;
                            end
                            else if (stat.sp_full)
                            begin
                                cmd.status = ST_OVER;
                            end
                            else
                            begin
                                cmd.wr_en   = 1'b1;
                                cmd.wr_addr = WA_PUSH;
                                cmd.wr_src  = WS_TOP;
                                cmd.sp_op   = SP_INC;
                            end
                        end
                    end
                    MODE_ADD, MODE_SUB, MODE_MAX, MODE_MIN:
                    begin
                        if (stat.out_free)
                        begin
                            cmd.emit   = 1'b1;
                            state_next = S_IDLE;
                            if (stat.sp_lt2)
                            begin
                                cmd.status = ST_UNDER;
                            end
                            else
                            begin
                                cmd.wr_en   = 1'b1;
                                cmd.wr_addr = WA_SEC;
                                cmd.wr_src  = WS_ALU;
                                cmd.sp_op   = SP_DEC;
                                if (mode_reg == MODE_SUB)
                                begin
                                    cmd.alu_op = ALU_SUB;
                                end
                                else if (mode_reg == MODE_MAX)
                                begin
                                    cmd.alu_op = ALU_MAX;
                                end
                                else if (mode_reg == MODE_MIN)
                                begin
                                    cmd.alu_op = ALU_MIN;
                                end
                            end
                        end
                    end
                    MODE_MUL:
                    begin
                        if (!stat.sp_lt2)
                        begin
                            cmd.prod_ld = 1'b1;
                            state_next  = S_MUL_WR;
                        end
                        else if (stat.out_free)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.status = ST_UNDER;
                            state_next = S_IDLE;
                        end
                    end
                    MODE_DIV:
                    begin
                        if (!stat.sp_lt2 && !stat.sec_zero)
                        begin
                            cmd.div_start = 1'b1;
                            state_next    = S_DIV_WR;
                        end
                        else if (stat.out_free)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.status = stat.sp_lt2 ? ST_UNDER : ST_DIVZ;
                            state_next = S_IDLE;
                        end
                    end
                    MODE_NEG:
                    begin
                        if (stat.out_free)
                        begin
                            cmd.emit   = 1'b1;
                            state_next = S_IDLE;
                            if (stat.sp_empty)
                            begin
                                cmd.status = ST_UNDER;
                            end
                            else
                            begin
                                cmd.wr_en  = 1'b1;
                                cmd.wr_src = WS_ALU;
                                cmd.alu_op = ALU_NEG;
                            end
                        end
                    end
                    MODE_SWAP:
                    begin
                        if (!stat.sp_lt2)
                        begin
                            // Old top goes under first; the new top is written with the result.
                            cmd.wr_en   = 1'b1;
                            cmd.wr_addr = WA_SEC;
                            cmd.wr_src  = WS_TOP;
                            state_next  = S_SWAP_WR;
                        end
                        else if (stat.out_free)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.status = ST_UNDER;
                            state_next = S_IDLE;
                        end
                    end
                    MODE_DUMP:
                    begin
                        if (!stat.sp_empty)
                        begin
                            state_next = S_DUMP_RD;
                        end
                        else if (stat.out_free)
                        begin
                            cmd.emit   = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    default:
                    begin
                        if (stat.out_free)
                        begin
                            cmd.emit   = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end
            S_MUL_WR:
            begin
                if (stat.out_free)
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_addr = WA_SEC;
                    cmd.wr_src  = WS_PROD;
                    cmd.sp_op   = SP_DEC;
                    cmd.emit    = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_DIV_WR:
            begin
                if (!stat.div_busy && stat.out_free)
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_addr = WA_SEC;
                    cmd.wr_src  = WS_QUO;
                    cmd.sp_op   = SP_DEC;
                    cmd.emit    = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_SWAP_WR:
            begin
                if (stat.out_free)
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_addr = WA_TOP;
                    cmd.wr_src  = WS_SEC;
                    cmd.emit    = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_DUMP_RD:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_dump = 1'b1;
                state_next  = S_DUMP_EM;
            end
            S_DUMP_EM:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_dump = 1'b1;
                if (stat.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.res_src = RES_DUMP;
                    if (stat.dump_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_DUMP_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg  <= MODE_CONST;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
        end
    end

    assign instr_stall = (state_reg != S_IDLE);

endmodule

`default_nettype wire

// ----- rtl/integer_stack_machine.sv -----
// Requests are taken one at a time, each starting with a registered read of the stack memory;
// MUL, DIV and SWAP add a write-back state, DIV waits there for the 32 steps of the iterative
// radix-2 divider, and DUMP reads and emits each entry in turn. A new request is accepted only
// once the previous one has loaded its last result into the result register.
// Reset: asynchronous, active low; empties the stack and drops any waiting result.
// Stack contents are not cleared; entries above the pointer may be read but never reach a result.
`default_nettype none

module integer_stack_machine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              instr_valid,
    output logic              instr_stall,
    input  ism_pkg::instr_t   instr,
    output logic              result_valid,
    input  logic              result_stall,
    output ism_pkg::result_t  result
);
    import ism_pkg::*;

    // Command and status between the sequencer and the stack datapath.
    cmd_t  cmd;
    stat_t stat;

    // Sequencer: take one request at a time, step it through read, execute and
    // write-back, and hold the final write until the result register is free so
    // the pointer update and the reported result always land together.
    ism_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .instr_valid (instr_valid),
        .instr_stall (instr_stall),
        .mode        (instr.mode),
        .stat        (stat),
        .cmd         (cmd)
    );

    // Datapath: stack memory with two read ports, operand registers, ALU,
    // product register, iterative divider and the result register, which lets a
    // new request in while the previous result still waits downstream.
    ism_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .instr_value  (instr.value),
        .stat         (stat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

// ----- rtl/ism_checker.sv -----
`default_nettype none
`include "integer_stack_machine_macros.svh"

module ism_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              instr_valid,
    input logic              instr_stall,
    input ism_pkg::instr_t   instr,
    input logic              result_valid,
    input logic              result_stall,
    input ism_pkg::result_t  result
);
    import ism_pkg::*;

    logic instr_acc;
    logic res_partial;
    logic pos_ok;

    assign instr_acc   = instr_valid && !instr_stall;
    assign res_partial = result_valid && !result.last;

    // Position lies inside the reported depth, or both are zero on an empty stack.
    assign pos_ok = ((result.depth == '0) && (result.position == '0))
                    || (DEPTH_W'(result.position) < result.depth);

    `ISM_ASSERT_HOLD(a_instr_hold, instr_valid, instr_stall, instr, "stalled request changed")

    `ISM_ASSERT_HOLD(a_result_hold, result_valid, result_stall, result, "stalled result changed")

    // An accepted request keeps the block busy in the following cycle.
    `ISM_ASSERT_NEXT(a_busy_after_accept, instr_acc, instr_stall, "request taken twice in a row")

    `ISM_ASSERT_IMP(a_pos_in_depth, result_valid, pos_ok, "position outside stack")

    // Only dump entries can come without last, and they are never errors.
    `ISM_ASSERT_IMP(a_partial_ok, res_partial, result.status == ST_OK, "error on a partial result")

endmodule

bind integer_stack_machine ism_checker u_checker (.*);

`default_nettype wire

// ----- tb/integer_stack_machine_tb.sv -----
module integer_stack_machine_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ism_pkg::*;

    // Modes 11 to 15 carry no operation and only report the top of stack.
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 4'd11;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 4'd15;

    // Divide is the slowest single step; allow for it after the last result.
    localparam int TAIL_CYCLES  = 40;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int REPORT_LINES = 40;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    instr_valid  = 1'b0;
    logic    instr_stall;
    instr_t  instr        = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    // Own copy of the stack, advanced on every accepted request.
    logic [WORD_W-1:0] stack_words [STACK_DEPTH];
    int unsigned       stack_fill = 0;

    // Results still owed by the block, oldest first.
    result_t expected_results [$];

    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    // Idling controls: sender bursts and receiver stall runs.
    bit          send_gaps   = 1'b0;
    bit          recv_stalls = 1'b0;
    int unsigned burst_left  = 0;
    bit          stall_phase = 1'b0;
    int unsigned stall_run   = 0;

    integer_stack_machine dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .instr_valid  (instr_valid),
        .instr_stall  (instr_stall),
        .instr        (instr),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        if (error_count < REPORT_LINES)
            $display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Stack predictor
    // ------------------------------------------------------------------

    // Result that reports the current top of stack, or zeros when empty.
    function automatic result_t top_report(input logic [STATUS_W-1:0] st);
        result_t r;
        r        = '0;
        r.depth  = DEPTH_W'(stack_fill);
        r.status = st;
        r.last   = 1'b1;
        if (stack_fill != 0)
        begin
            r.value_res = stack_words[stack_fill - 1];
            r.position  = POS_W'(stack_fill - 1);
        end
        return r;
    endfunction

    // Signed quotient truncated toward zero; the most negative word over -1 wraps.
    function automatic logic [WORD_W-1:0] truncated_quotient(input logic [WORD_W-1:0] num,
                                                             input logic [WORD_W-1:0] den);
        logic [WORD_W-1:0] mag_n;
        logic [WORD_W-1:0] mag_d;
        logic [WORD_W-1:0] q;
        mag_n = num[WORD_W-1] ? -num : num;
        mag_d = den[WORD_W-1] ? -den : den;
        q     = mag_n / mag_d;
        return (num[WORD_W-1] ^ den[WORD_W-1]) ? -q : q;
    endfunction

    // Apply one instruction to the stack copy and queue the results it owes.
    task automatic predict_instr(input logic [MODE_W-1:0] op, input logic [WORD_W-1:0] word);
        logic [WORD_W-1:0] top;
        logic [WORD_W-1:0] sec;
        logic [WORD_W-1:0] res;
        result_t           item;
        case (op)
            MODE_CONST, MODE_DUP:
            begin
                if (op == MODE_DUP && stack_fill < 1)
                    expected_results.push_back(top_report(ST_UNDER));
                else if (stack_fill >= STACK_DEPTH)
                    expected_results.push_back(top_report(ST_OVER));
                else
                begin
                    if (op == MODE_DUP)
                        stack_words[stack_fill] = stack_words[stack_fill - 1];
                    else
                        stack_words[stack_fill] = word;
                    stack_fill++;
                    expected_results.push_back(top_report(ST_OK));
                end
            end
            MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV, MODE_MAX, MODE_MIN, MODE_SWAP:
            begin
                if (stack_fill < 2)
                    expected_results.push_back(top_report(ST_UNDER));
                else
                begin
                    top = stack_words[stack_fill - 1];
                    sec = stack_words[stack_fill - 2];
                    if (op == MODE_SWAP)
                    begin
                        stack_words[stack_fill - 1] = sec;
                        stack_words[stack_fill - 2] = top;
                        expected_results.push_back(top_report(ST_OK));
                    end
                    else if (op == MODE_DIV && sec == '0)
                        expected_results.push_back(top_report(ST_DIVZ));
                    else
                    begin
                        case (op)
                            MODE_ADD: res = top + sec;
                            MODE_SUB: res = top - sec;
                            MODE_MUL: res = top * sec;
                            MODE_DIV: res = truncated_quotient(top, sec);
                            MODE_MAX: res = ($signed(sec) > $signed(top)) ? sec : top;
                            default:  res = ($signed(sec) > $signed(top)) ? top : sec;
                        endcase
                        stack_words[stack_fill - 2] = res;
                        stack_fill--;
                        expected_results.push_back(top_report(ST_OK));
                    end
                end
            end
            MODE_NEG:
            begin
                if (stack_fill < 1)
                    expected_results.push_back(top_report(ST_UNDER));
                else
                begin
                    stack_words[stack_fill - 1] = -stack_words[stack_fill - 1];
                    expected_results.push_back(top_report(ST_OK));
                end
            end
            MODE_DUMP:
            begin
                if (stack_fill == 0)
                    expected_results.push_back(top_report(ST_OK));
                else
                    for (int unsigned idx = 0; idx < stack_fill; idx++)
                    begin
                        item           = '0;
                        item.value_res = stack_words[idx];
                        item.position  = POS_W'(idx);
                        item.depth     = DEPTH_W'(stack_fill);
                        item.status    = ST_OK;
                        item.last      = (idx + 1 == stack_fill);
                        expected_results.push_back(item);
                    end
            end
            default:
                expected_results.push_back(top_report(ST_OK));
        endcase
    endtask

    // ------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------

    // Drive one request, hold it until accepted, then predict. At the end of a
    // burst drop valid, put junk on the payload and idle for a while.
    task automatic send_instr(input logic [MODE_W-1:0] op, input logic [WORD_W-1:0] word);
        instr_valid <= 1'b1;
        instr       <= '{mode: op, value: word};
        do
            @(posedge clk);
        while (instr_stall);
        predict_instr(op, word);
        if (send_gaps)
        begin
            if (burst_left == 0)
            begin
                instr_valid <= 1'b0;
                instr       <= '{mode: MODE_W'($urandom), value: $urandom};
                repeat ($urandom_range(1, 8)) @(posedge clk);
                burst_left = $urandom_range(1, 10);
            end
            else
                burst_left--;
        end
    endtask

    task automatic set_idling(input bit gaps, input bit stalls);
        send_gaps   = gaps;
        recv_stalls = stalls;
    endtask

    // Drop valid and wait until every owed result has come back.
    task automatic wait_for_results();
        instr_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mix of extremes, small values around zero and full-range words.
    function automatic logic [WORD_W-1:0] random_word();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 2)
        begin
            case ($urandom_range(0, 4))
                0:       return '0;
                1:       return 32'd1;
                2:       return '1;
                3:       return 32'h7FFF_FFFF;
                default: return 32'h8000_0000;
            endcase
        end
        else if (pick < 4)
            return WORD_W'(int'($urandom_range(0, 16)) - 8);
        else
            return $urandom;
    endfunction

    // Mostly well-formed programs: push while shallow, otherwise mix in every
    // operation, with a little underflow and spare-mode noise.
    function automatic logic [MODE_W-1:0] pick_mode();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (stack_fill < 2 && roll < 70)
            return MODE_CONST;
        if (roll < 35) return MODE_CONST;
        if (roll < 40) return MODE_DUP;
        if (roll < 47) return MODE_ADD;
        if (roll < 54) return MODE_SUB;
        if (roll < 60) return MODE_MUL;
        if (roll < 68) return MODE_DIV;
        if (roll < 73) return MODE_MAX;
        if (roll < 78) return MODE_MIN;
        if (roll < 84) return MODE_NEG;
        if (roll < 90) return MODE_SWAP;
        if (roll < 95) return MODE_DUMP;
        if (roll < 98) return MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
        return MODE_CONST;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty stack: empty dump, underflow on each arity, spare mode.
    task automatic test_empty_stack();
        send_instr(MODE_DUMP, $urandom);
        send_instr(MODE_ADD, $urandom);
        send_instr(MODE_NEG, $urandom);
        send_instr(MODE_DUP, $urandom);
        send_instr(MODE_SWAP, $urandom);
        send_instr(MODE_SPARE_HI, $urandom);
    endtask

    // Wrap-around, most negative quotient, divide by zero and every operation.
    task automatic test_arithmetic_edges();
        send_instr(MODE_CONST, '1);
        send_instr(MODE_DIV, $urandom);
        send_instr(MODE_CONST, 32'h8000_0000);
        send_instr(MODE_DIV, $urandom);
        send_instr(MODE_NEG, $urandom);
        send_instr(MODE_CONST, '0);
        send_instr(MODE_CONST, 32'd7);
        send_instr(MODE_DIV, $urandom);
        send_instr(MODE_SWAP, $urandom);
        send_instr(MODE_DUMP, $urandom);
        send_instr(MODE_ADD, $urandom);
        send_instr(MODE_CONST, 32'h7FFF_FFFF);
        send_instr(MODE_ADD, $urandom);
        send_instr(MODE_SUB, $urandom);
        send_instr(MODE_CONST, -32'sd3);
        send_instr(MODE_DUP, $urandom);
        send_instr(MODE_MAX, $urandom);
        send_instr(MODE_MIN, $urandom);
        send_instr(MODE_CONST, -32'sd7);
        send_instr(MODE_MUL, $urandom);
        send_instr(MODE_CONST, 32'h1234_5678);
        send_instr(MODE_DIV, $urandom);
        send_instr(MODE_SPARE_LO, $urandom);
        send_instr(MODE_DUMP, $urandom);
    endtask

    // Fill to the brim, hit overflow, dump all entries, then fold part of it back down.
    task automatic test_full_stack();
        while (stack_fill < STACK_DEPTH)
            send_instr(MODE_CONST, random_word());
        send_instr(MODE_CONST, random_word());
        send_instr(MODE_DUP, $urandom);
        send_instr(MODE_SWAP, $urandom);
        send_instr(MODE_NEG, $urandom);
        send_instr(MODE_DUMP, $urandom);
        while (stack_fill > 40)
            send_instr(MODE_W'(MODE_ADD + $urandom_range(0, 5)), $urandom);
        send_instr(MODE_DUMP, $urandom);
    endtask

    // Random programs; reshuffle idling every so often so that stretches with
    // and without gaps and stalls both occur.
    task automatic test_random_programs(input int unsigned count);
        logic [MODE_W-1:0] op;
        for (int unsigned n = 0; n < count; n++)
        begin
            if (n % 25 == 0)
                set_idling($urandom_range(0, 1), $urandom_range(0, 1));
            op = pick_mode();
            send_instr(op, (op == MODE_CONST) ? random_word() : $urandom);
        end
    endtask

    // ------------------------------------------------------------------
    // Result checker and receiver stall pattern
    // ------------------------------------------------------------------

    task automatic check_result(input result_t got);
        result_t want;
        if (expected_results.size() == 0)
        begin
            report_mismatch($sformatf("result with nothing owed: value_res %0h position %0d",
                                      got.value_res, got.position));
            return;
        end
        want = expected_results.pop_front();
        if (got.value_res !== want.value_res)
            report_mismatch($sformatf("value_res want %0h got %0h",
                                      want.value_res, got.value_res));
        if (got.position !== want.position)
            report_mismatch($sformatf("position want %0d got %0d", want.position, got.position));
        if (got.depth !== want.depth)
            report_mismatch($sformatf("depth want %0d got %0d", want.depth, got.depth));
        if (got.status !== want.status)
            report_mismatch($sformatf("status want %0d got %0d", want.status, got.status));
        if (got.last !== want.last)
            report_mismatch($sformatf("last want %0b got %0b", want.last, got.last));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            check_result(result);
        // Alternate runs of stalling and free cycles of random length.
        if (stall_run == 0)
        begin
            stall_phase = !stall_phase;
            stall_run   = stall_phase ? $urandom_range(1, 5) : $urandom_range(1, 12);
        end
        stall_run--;
        result_stall <= recv_stalls && stall_phase;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: timed out with %0d results owed", expected_results.size());
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idling(1'b0, 1'b0);
        test_empty_stack();
        set_idling(1'b1, 1'b1);
        test_arithmetic_edges();
        set_idling(1'b0, 1'b1);
        test_full_stack();
        test_random_programs(30);

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/ism_pkg.sv
rtl/ism_divider.sv
rtl/ism_datapath.sv
rtl/ism_ctrl.sv
rtl/integer_stack_machine.sv
rtl/ism_checker.sv
tb/integer_stack_machine_tb.sv
